// ----- rtl/core/etcg_pkg.sv -----
// etcg_pkg: shared types and constants for the edge trigger capture gate
// used by the channel interfaces, the trigger controller and the top level
// no dependencies

package etcg_pkg;

    // field widths
    localparam int SAMPLE_W = 12;
    localparam int COUNT_W  = 11;
    localparam int MODE_W   = 2;
    localparam int OP_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // largest frame length
    localparam logic [COUNT_W-1:0] BUFFER_SIZE = COUNT_W'(1024);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MODE      = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_COUNT     = CFG_IDX_W'(2);

    // reset values of the configuration registers
    localparam logic [SAMPLE_W-1:0] THRESHOLD_RST = SAMPLE_W'(2032);
    localparam logic [COUNT_W-1:0]  COUNT_RST     = COUNT_W'(992);

    typedef enum logic [OP_W-1:0] {
        OP_SAMPLE = 2'd0,
        OP_START  = 2'd1,
        OP_STOP   = 2'd2
    } t_opcode;

    typedef enum logic [MODE_W-1:0] {
        MODE_TOGGLE  = 2'd0,
        MODE_FALLING = 2'd1,
        MODE_RISING  = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_DIR     = 3'd1,
        PH_WATCH   = 3'd2,
        PH_CAPTURE = 3'd3
    } t_phase;

    // per-item decision of the trigger controller
    typedef struct packed {
        logic valid;
        logic last;
    } t_result;

endpackage

// ----- rtl/core/etcg_in_if.sv -----
// etcg_in_if: valid/ready channel carrying commands and adc samples
// depends on etcg_pkg

interface etcg_in_if;
    logic                          valid;
    logic                          ready;
    logic [etcg_pkg::OP_W-1:0]     opcode;
    logic [etcg_pkg::SAMPLE_W-1:0] sample_value;

    modport source (output valid, output opcode, output sample_value, input ready);
    modport sink   (input valid, input opcode, input sample_value, output ready);
endinterface

// ----- rtl/core/etcg_out_if.sv -----
// etcg_out_if: valid/ready channel carrying captured samples
// depends on etcg_pkg

interface etcg_out_if;
    logic                          valid;
    logic                          ready;
    logic [etcg_pkg::SAMPLE_W-1:0] captured_sample;
    logic                          frame_last;

    modport source (output valid, output captured_sample, output frame_last, input ready);
    modport sink   (input valid, input captured_sample, input frame_last, output ready);
endinterface

// ----- rtl/core/etcg_ctrl.sv -----
// etcg_ctrl: arm/fire state machine and frame counter
// depends on etcg_pkg

module etcg_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [etcg_pkg::OP_W-1:0]     i_opcode,
    input  logic [etcg_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [etcg_pkg::SAMPLE_W-1:0] i_threshold,
    input  logic [etcg_pkg::MODE_W-1:0]   i_mode,
    input  logic [etcg_pkg::COUNT_W-1:0]  i_count,
    output etcg_pkg::t_result             o_res
);

    etcg_pkg::t_phase             r_phase, n_phase;
    logic                         r_wait_above, n_wait_above;
    logic                         r_fire_next, n_fire_next;
    logic [etcg_pkg::COUNT_W-1:0] r_remaining, n_remaining;

    logic                         above, below, hit;
    logic [etcg_pkg::COUNT_W-1:0] dec_remaining;
    logic [etcg_pkg::COUNT_W-1:0] load_count;

    // strict compares against the live threshold
    assign above = i_sample > i_threshold;
    assign below = i_sample < i_threshold;
    assign hit   = r_wait_above ? above : below;

    assign dec_remaining = (r_remaining == '0) ? '0 : r_remaining - 1'b1;
    assign load_count    = (i_count == '0) ? etcg_pkg::COUNT_W'(1) : i_count;

    // next state
    always_comb begin
        n_phase      = r_phase;
        n_wait_above = r_wait_above;
        n_fire_next  = r_fire_next;
        n_remaining  = r_remaining;
        unique case (etcg_pkg::t_opcode'(i_opcode))
            etcg_pkg::OP_STOP: begin
                n_phase      = etcg_pkg::PH_IDLE;
                n_wait_above = 1'b0;
                n_fire_next  = 1'b0;
                n_remaining  = '0;
            end
            etcg_pkg::OP_START: begin
                n_remaining = '0;
                unique case (etcg_pkg::t_mode'(i_mode))
                    etcg_pkg::MODE_TOGGLE: begin
                        n_phase      = etcg_pkg::PH_DIR;
                        n_wait_above = 1'b0;
                        n_fire_next  = 1'b1;
                    end
                    etcg_pkg::MODE_FALLING: begin
                        n_phase      = etcg_pkg::PH_WATCH;
                        n_wait_above = 1'b1;
                        n_fire_next  = 1'b0;
                    end
                    default: begin
                        // rising edge, also for the unused mode code
                        n_phase      = etcg_pkg::PH_WATCH;
                        n_wait_above = 1'b0;
                        n_fire_next  = 1'b0;
                    end
                endcase
            end
            etcg_pkg::OP_SAMPLE: begin
                unique case (r_phase)
                    etcg_pkg::PH_DIR: begin
                        n_wait_above = below;
                        n_phase      = etcg_pkg::PH_WATCH;
                    end
                    etcg_pkg::PH_WATCH: begin
                        if (hit) begin
                            if (!r_fire_next) begin
                                n_fire_next  = 1'b1;
                                n_wait_above = !r_wait_above;
                            end else begin
                                n_phase     = etcg_pkg::PH_CAPTURE;
                                n_remaining = load_count;
                            end
                        end
                    end
                    etcg_pkg::PH_CAPTURE: begin
                        n_remaining = dec_remaining;
                        if (dec_remaining == '0) begin
                            n_phase      = etcg_pkg::PH_IDLE;
                            n_wait_above = 1'b0;
                            n_fire_next  = 1'b0;
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
            default: begin
                // unused opcode leaves the state alone
                n_phase = r_phase;
            end
        endcase
    end

    // result for the current item
    always_comb begin
        o_res.valid = 1'b0;
        o_res.last  = 1'b0;
        if (etcg_pkg::t_opcode'(i_opcode) == etcg_pkg::OP_SAMPLE &&
            r_phase == etcg_pkg::PH_CAPTURE) begin
            o_res.valid = 1'b1;
            o_res.last  = (dec_remaining == '0);
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= etcg_pkg::PH_IDLE;
            r_wait_above <= 1'b0;
            r_fire_next  <= 1'b0;
            r_remaining  <= '0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_wait_above <= n_wait_above;
            r_fire_next  <= n_fire_next;
            r_remaining  <= n_remaining;
        end
    end

endmodule

// ----- rtl/core/edge_trigger_capture_gate.sv -----
// edge_trigger_capture_gate: top level of the scope edge trigger and capture gate
// depends on etcg_pkg, etcg_in_if, etcg_out_if and etcg_ctrl
//
// Usage:
//   i_item carries commands (sample, start, stop) with a 12-bit adc sample.
//   o_result carries the samples captured after the trigger fires, with
//   frame_last set on the final sample of each frame.
//   Configuration (threshold, mode, frame length) is written through i_cfg_we /
//   i_cfg_idx / i_cfg_data; the user must do so only while the block is idle,
//   which the block itself does not enforce.
// Path: input register, then etcg_ctrl decision, then result register.
// Throughput: one item per cycle unless o_result stalls; the input register
//   and the result register each pass on one item per cycle, with the arm/fire
//   state updated by threshold compares and an 11-bit decrement.
// Stalls: the result register holds while o_result.ready is low; the input
//   register still takes one more item, then i_item.ready drops until the
//   result is taken.
// Reset: synchronous, active low; registers return to their reset values,
//   the trigger goes idle and both pipeline registers are emptied.

module edge_trigger_capture_gate (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    etcg_in_if.sink                         i_item,
    etcg_out_if.source                      o_result,
    input  logic                            i_cfg_we,
    input  logic [etcg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [etcg_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // configuration registers
    logic [etcg_pkg::SAMPLE_W-1:0] r_threshold;
    logic [etcg_pkg::MODE_W-1:0]   r_mode;
    logic [etcg_pkg::COUNT_W-1:0]  r_count;
    logic [etcg_pkg::COUNT_W-1:0]  n_count;

    // input and result registers
    logic                          r_in_valid;
    logic [etcg_pkg::OP_W-1:0]     r_in_op;
    logic [etcg_pkg::SAMPLE_W-1:0] r_in_sample;
    logic                          r_out_valid;
    logic [etcg_pkg::SAMPLE_W-1:0] r_out_sample;
    logic                          r_out_last;

    logic              advance;
    logic              step;
    etcg_pkg::t_result res;

    // saturate the frame length into one to buffer size
    always_comb begin
        n_count = i_cfg_data[etcg_pkg::COUNT_W-1:0];
        if (n_count == '0) begin
            n_count = etcg_pkg::COUNT_W'(1);
        end else if (n_count > etcg_pkg::BUFFER_SIZE) begin
            n_count = etcg_pkg::BUFFER_SIZE;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= etcg_pkg::THRESHOLD_RST;
            r_mode      <= etcg_pkg::MODE_TOGGLE;
            r_count     <= etcg_pkg::COUNT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                etcg_pkg::REG_THRESHOLD: r_threshold <= i_cfg_data;
                etcg_pkg::REG_MODE:      r_mode      <= i_cfg_data[etcg_pkg::MODE_W-1:0];
                etcg_pkg::REG_COUNT:     r_count     <= n_count;
                default: begin
                    r_count <= r_count;
                end
            endcase
        end
    end

    // pipeline flow control
    assign advance      = !r_out_valid || o_result.ready;
    assign step         = r_in_valid && advance;
    assign i_item.ready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.ready && i_item.valid) begin
            r_in_op     <= i_item.opcode;
            r_in_sample <= i_item.sample_value;
        end
    end

    // trigger state machine
    etcg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_opcode    (r_in_op),
        .i_sample    (r_in_sample),
        .i_threshold (r_threshold),
        .i_mode      (r_mode),
        .i_count     (r_count),
        .o_res       (res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= step && res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res.valid) begin
            r_out_sample <= r_in_sample;
            r_out_last   <= res.last;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.captured_sample = r_out_sample;
    assign o_result.frame_last      = r_out_last;

endmodule

// ----- rtl/core/etcg_checker.sv -----
// etcg_checker: port-level assertions for edge_trigger_capture_gate
// depends on etcg_pkg; bound to the top level at the end of this file

module etcg_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_ready,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [etcg_pkg::SAMPLE_W-1:0] i_out_sample,
    input  logic                          i_out_last
);

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

    // with no result pending the input side must take a transfer
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty result register");

    // a stalled result keeps its payload
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_sample) && $stable(i_out_last))
        else $error("stalled result changed");

endmodule

bind edge_trigger_capture_gate etcg_checker u_etcg_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_item.ready),
    .i_out_valid  (o_result.valid),
    .i_out_ready  (o_result.ready),
    .i_out_sample (o_result.captured_sample),
    .i_out_last   (o_result.frame_last)
);
